/* rtl/core/hcmm_pkg.sv */
// Shared types and constants of the handheld console memory map.
// Used by the interfaces, controller, datapath and top level; depends on nothing.
package hcmm_pkg;

	localparam int unsigned STORE_DEPTH = 65536;
	localparam int unsigned ADDR_W      = 16;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [7:0]        byte_t;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_LOAD  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// region limits (the _HI values are inclusive upper bounds)
	localparam addr_t VRAM_HI   = 16'h9FFF;
	localparam addr_t ROM_HI    = 16'h7FFF;
	localparam addr_t ERAM_HI   = 16'hBFFF;
	localparam addr_t WRAM_HI   = 16'hDFFF;
	localparam addr_t ECHO_LO   = 16'hE000;
	localparam addr_t ECHO_HI   = 16'hFDFF;
	localparam addr_t OAM_HI    = 16'hFE9F;
	localparam addr_t UNUSED_HI = 16'hFEFF;
	localparam addr_t ECHO_OFS  = 16'h2000;
	localparam addr_t OAM_BASE  = 16'hFE00;

	// I/O registers with special handling
	localparam addr_t JOYP_ADDR = 16'hFF00;
	localparam addr_t DIV_ADDR  = 16'hFF04;
	localparam addr_t IF_ADDR   = 16'hFF0F;
	localparam addr_t STAT_ADDR = 16'hFF41;
	localparam addr_t LY_ADDR   = 16'hFF44;
	localparam addr_t DMA_ADDR  = 16'hFF46;
	localparam addr_t WY_ADDR   = 16'hFF4A;
	localparam addr_t WX_ADDR   = 16'hFF4B;

	localparam byte_t MODE_MASK      = 8'b0000_0011;
	localparam byte_t IF_SET_MASK    = 8'hE0;
	localparam byte_t STAT_KEEP_MASK = 8'h87;
	localparam byte_t STAT_DATA_MASK = 8'h78;
	localparam byte_t JOYP_KEEP_MASK = 8'hCF;
	localparam byte_t JOYP_DATA_MASK = 8'h30;
	localparam byte_t OPEN_BUS       = 8'hFF;

	localparam logic [1:0] MODE_OAM_SCAN = 2'd2;
	localparam logic [1:0] MODE_DRAW     = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic dma_rd;
		logic dma_wr;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic dma_start;
		logic dma_last;
	} status_t;

endpackage

/* rtl/core/hcmm_access_if.sv */
// Input channel of the memory map: one bus access per item.
// Depends on hcmm_pkg.
interface hcmm_access_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	hcmm_pkg::addr_t    address;
	hcmm_pkg::byte_t    write_byte;
	hcmm_pkg::byte_t    joypad_value;

	modport source (output valid, action, address, write_byte, joypad_value, input ready);
	modport sink   (input valid, action, address, write_byte, joypad_value, output ready);
endinterface

/* rtl/core/hcmm_result_if.sv */
// Output channel of the memory map: one result item per access.
// Depends on hcmm_pkg.
interface hcmm_result_if;
	logic               valid;
	logic               ready;
	hcmm_pkg::byte_t    read_byte;
	logic               write_dropped;

	modport source (output valid, read_byte, write_dropped, input ready);
	modport sink   (input valid, read_byte, write_dropped, output ready);
endinterface

/* rtl/core/hcmm_ctrl.sv */
// Controller of the memory map: sequences capture, execute and the OAM DMA copy,
// and owns both handshakes. Depends on hcmm_pkg.
module hcmm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  hcmm_pkg::status_t   status,
	output hcmm_pkg::cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXEC   = 4'b0010,
		ST_DMA_RD = 4'b0100,
		ST_DMA_WR = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// take an item only in idle and when the result register is empty or draining now
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.capture = in_valid && in_ready;
		cmd.exec    = (state_q == ST_EXEC);
		cmd.dma_rd  = (state_q == ST_DMA_RD);
		cmd.dma_wr  = (state_q == ST_DMA_WR);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.capture) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = status.dma_start ? ST_DMA_RD : ST_IDLE;
			end
			ST_DMA_RD: begin
				state_d = ST_DMA_WR;
			end
			ST_DMA_WR: begin
				state_d = status.dma_last ? ST_IDLE : ST_DMA_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/hcmm_datapath.sv */
// Datapath of the memory map: 64 KiB byte store, address decode, write merge,
// result register and the DMA copy counter. Depends on hcmm_pkg.
module hcmm_datapath #(
	parameter int unsigned DMA_LENGTH = 160
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hcmm_pkg::cmd_t      cmd,
	output hcmm_pkg::status_t   status,
	input  logic [1:0]          action,
	input  hcmm_pkg::addr_t     address,
	input  hcmm_pkg::byte_t     write_byte,
	input  hcmm_pkg::byte_t     joypad_value,
	output hcmm_pkg::byte_t     read_byte,
	output logic                write_dropped
);

	localparam int unsigned IDX_W = (DMA_LENGTH > 1) ? $clog2(DMA_LENGTH) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DMA_LENGTH - 1);

	hcmm_pkg::byte_t store_q [hcmm_pkg::STORE_DEPTH];

	logic [1:0]        action_q;
	hcmm_pkg::addr_t   addr_q;
	hcmm_pkg::addr_t   map_addr_q;
	hcmm_pkg::byte_t   data_q;
	hcmm_pkg::byte_t   joy_q;
	hcmm_pkg::byte_t   rd_a_q;
	hcmm_pkg::byte_t   stat_q;
	hcmm_pkg::byte_t   read_byte_q;
	logic              dropped_q;
	logic [IDX_W-1:0]  idx_q;

	hcmm_pkg::addr_t   in_map_addr;
	hcmm_pkg::addr_t   rd_addr;
	logic              wr_en;
	hcmm_pkg::addr_t   wr_addr;
	hcmm_pkg::byte_t   wr_data;
	logic              ex_wr;
	hcmm_pkg::byte_t   ex_wr_data;
	hcmm_pkg::byte_t   ex_rd;
	logic              ex_drop;
	logic              ex_dma;
	logic [1:0]        mode;

	// echo RAM folds onto WRAM for decoded accesses only
	always_comb begin
		in_map_addr = address;
		if ((action == hcmm_pkg::ACT_READ || action == hcmm_pkg::ACT_WRITE)
				&& address >= hcmm_pkg::ECHO_LO && address <= hcmm_pkg::ECHO_HI) begin
			in_map_addr = address - hcmm_pkg::ECHO_OFS;
		end
	end

	assign rd_addr = cmd.dma_rd ? {data_q, 8'(idx_q)} : in_map_addr;

	// store: one write port, one muxed read port and one read port fixed on STAT
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		rd_a_q <= store_q[rd_addr];
		stat_q <= store_q[hcmm_pkg::STAT_ADDR];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q   <= action;
			addr_q     <= address;
			map_addr_q <= in_map_addr;
			data_q     <= write_byte;
			joy_q      <= joypad_value;
		end
		if (cmd.exec) begin
			read_byte_q <= ex_rd;
			dropped_q   <= ex_drop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.exec) begin
			idx_q <= '0;
		end else if (cmd.dma_wr) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	assign mode = stat_q[1:0] & hcmm_pkg::MODE_MASK[1:0];

	// decode the captured access against the stored byte and STAT mode
	always_comb begin
		ex_wr      = 1'b0;
		ex_wr_data = data_q;
		ex_rd      = '0;
		ex_drop    = 1'b0;
		ex_dma     = 1'b0;
		unique case (action_q)
			hcmm_pkg::ACT_READ: begin
				priority if (addr_q <= hcmm_pkg::VRAM_HI) ex_rd = rd_a_q;
				else if (addr_q <= hcmm_pkg::ERAM_HI) ex_rd = hcmm_pkg::OPEN_BUS;
				else if (addr_q <= hcmm_pkg::ECHO_HI) ex_rd = rd_a_q;
				else if (addr_q <= hcmm_pkg::OAM_HI) begin
					ex_rd = (mode == hcmm_pkg::MODE_OAM_SCAN || mode == hcmm_pkg::MODE_DRAW)
						? hcmm_pkg::OPEN_BUS : rd_a_q;
				end
				else if (addr_q <= hcmm_pkg::UNUSED_HI) ex_rd = hcmm_pkg::OPEN_BUS;
				else if (addr_q == hcmm_pkg::JOYP_ADDR) ex_rd = joy_q;
				else if (addr_q == hcmm_pkg::IF_ADDR) ex_rd = rd_a_q | hcmm_pkg::IF_SET_MASK;
				else ex_rd = rd_a_q;
			end
			hcmm_pkg::ACT_WRITE: begin
				priority if (addr_q <= hcmm_pkg::ROM_HI) ex_drop = 1'b1;
				else if (addr_q <= hcmm_pkg::VRAM_HI) ex_wr = 1'b1;
				else if (addr_q <= hcmm_pkg::ERAM_HI) ex_drop = 1'b1;
				else if (addr_q <= hcmm_pkg::ECHO_HI) ex_wr = 1'b1;
				else if (addr_q <= hcmm_pkg::OAM_HI) begin
					ex_drop = (mode == hcmm_pkg::MODE_DRAW);
					ex_wr   = !ex_drop;
				end
				else if (addr_q <= hcmm_pkg::UNUSED_HI) ex_drop = 1'b1;
				else if (addr_q == hcmm_pkg::JOYP_ADDR) begin
					ex_wr      = 1'b1;
					ex_wr_data = (rd_a_q & hcmm_pkg::JOYP_KEEP_MASK)
						| (data_q & hcmm_pkg::JOYP_DATA_MASK);
				end
				else if (addr_q == hcmm_pkg::DIV_ADDR) begin
					ex_wr      = 1'b1;
					ex_wr_data = '0;
				end
				else if (addr_q == hcmm_pkg::STAT_ADDR) begin
					ex_wr      = 1'b1;
					ex_wr_data = (rd_a_q & hcmm_pkg::STAT_KEEP_MASK)
						| (data_q & hcmm_pkg::STAT_DATA_MASK);
				end
				else if (addr_q == hcmm_pkg::LY_ADDR) ex_drop = 1'b1;
				else if (addr_q == hcmm_pkg::DMA_ADDR) begin
					ex_wr  = 1'b1;
					ex_dma = 1'b1;
				end
				else if (addr_q == hcmm_pkg::WY_ADDR || addr_q == hcmm_pkg::WX_ADDR) begin
					ex_drop = (mode == hcmm_pkg::MODE_DRAW);
					ex_wr   = !ex_drop;
				end
				else ex_wr = 1'b1;
			end
			hcmm_pkg::ACT_LOAD: begin
				ex_wr = 1'b1;
			end
			default: begin
				ex_wr = 1'b0;
			end
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = map_addr_q;
		wr_data = ex_wr_data;
		if (cmd.exec) begin
			wr_en = ex_wr;
		end else if (cmd.dma_wr) begin
			wr_en   = 1'b1;
			wr_addr = hcmm_pkg::OAM_BASE + hcmm_pkg::addr_t'(idx_q);
			wr_data = rd_a_q;
		end
	end

	assign status.dma_start = ex_dma;
	assign status.dma_last  = (idx_q == IDX_LAST);

	assign read_byte     = read_byte_q;
	assign write_dropped = dropped_q;

endmodule

/* rtl/core/handheld_console_memory_map_core.sv */
// Handheld console memory map core (no cartridge bank control).
// Result valid from the edge after the accepting one; no item is accepted while one
// executes or its result waits untaken. A DMA register write runs the copy (read, then
// write each byte) before the next item is taken; its result is posted before the copy.
// Reset clears the controller and result-valid state; store contents are undefined
// until written, with no clearing pass.
module handheld_console_memory_map_core #(
	parameter int unsigned DMA_LENGTH = 160
) (
	input  logic                 clk,
	input  logic                 arst_n,
	hcmm_access_if.sink          access,
	hcmm_result_if.source        result
);

	hcmm_pkg::cmd_t    cmd;
	hcmm_pkg::status_t status;

	hcmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (access.valid),
		.in_ready  (access.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	hcmm_datapath #(
		.DMA_LENGTH (DMA_LENGTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.action        (access.action),
		.address       (access.address),
		.write_byte    (access.write_byte),
		.joypad_value  (access.joypad_value),
		.read_byte     (result.read_byte),
		.write_dropped (result.write_dropped)
	);

endmodule
